FILE: sv/clt_pkg.sv
// ----------------------------------------------------------------------------
// Command line tokenizer package
// Field widths, character codes, reader states and the emit request type.
// ----------------------------------------------------------------------------
package clt_pkg;

	// Field widths of the channels.
	localparam int BYTE_W = 8;
	localparam int WORD_W = BYTE_W + 1;
	localparam int POS_W  = 6;
	localparam int CNT_W  = 6;
	localparam int CFG_W  = 7;

	// Character codes.
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
	localparam logic [BYTE_W-1:0] CH_NUL   = 8'd0;

	// Token counter saturation value and line limit after reset.
	localparam logic [CNT_W-1:0] CNT_SAT     = 6'd63;
	localparam logic [CFG_W-1:0] LIMIT_RESET = 7'd64;

	// Read-out sequencer states.
	typedef enum logic [1:0] {
		RD_IDLE,
		RD_FETCH,
		RD_SEND
	} rd_state_t;

	// Line-end request from the writer to the reader.
	typedef struct packed {
		logic             valid;
		logic             keep_mark;
		logic [CNT_W-1:0] tokens;
	} emit_req_t;

endpackage

FILE: sv/clt_byte_if.sv
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel carrying one received character per transfer.
// ----------------------------------------------------------------------------
interface clt_byte_if;
	logic                       valid;
	logic                       ready;
	logic [clt_pkg::BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

FILE: sv/clt_tok_if.sv
// ----------------------------------------------------------------------------
// Token byte channel
// Valid/ready channel carrying one stored line byte with its flags per transfer.
// ----------------------------------------------------------------------------
interface clt_tok_if;
	logic                       valid;
	logic                       ready;
	logic [clt_pkg::POS_W-1:0]  position;
	logic [clt_pkg::BYTE_W-1:0] value;
	logic                       token_start;
	logic [clt_pkg::CNT_W-1:0]  token_count;
	logic                       last;

	modport source (
		output valid, output position, output value, output token_start,
		output token_count, output last, input ready
	);
	modport sink (
		input valid, input position, input value, input token_start,
		input token_count, input last, output ready
	);
endinterface

FILE: sv/clt_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying the line limit register write data.
// ----------------------------------------------------------------------------
interface clt_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [clt_pkg::CFG_W-1:0] line_limit;

	modport source (output valid, output line_limit, input ready);
	modport sink (input valid, input line_limit, output ready);
endinterface

FILE: sv/clt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module clt_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds between reads.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/clt_writer.sv
// ----------------------------------------------------------------------------
// Tokenizer line writer
// Accepts received bytes, builds the stored line and requests the read-out.
// ----------------------------------------------------------------------------
module clt_writer #(
	parameter int LINE_MAX = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	clt_byte_if.sink                    rx,
	clt_cfg_if.sink                     cfg,
	input  logic                        done,
	output logic                        we,
	output logic [$clog2(LINE_MAX)-1:0] waddr,
	output logic [clt_pkg::WORD_W-1:0]  wdata,
	output logic [$clog2(LINE_MAX)-1:0] end_pos,
	output clt_pkg::emit_req_t          req
);
	import clt_pkg::*;

	localparam int AW    = $clog2(LINE_MAX);
	localparam int LIM_W = $clog2(LINE_MAX + 1);
	localparam int CW    = (LIM_W > CFG_W) ? LIM_W : CFG_W;

	logic [CFG_W-1:0] line_limit_q;
	logic             started_q;
	logic             in_token_q;
	logic [AW-1:0]    wp_q;
	logic [CNT_W-1:0] tokens_q;
	logic             emit_q;
	logic             keep_mark_q;
	logic [AW-1:0]    end_q;
	logic [CNT_W-1:0] emit_tokens_q;

	logic             accept;
	logic             eol;
	logic             is_space;
	logic [CW-1:0]    lim;
	logic [CW-1:0]    wp_cur;
	logic             in_token_cur;
	logic [CNT_W-1:0] tokens_cur;
	logic [CW-1:0]    wp_new;
	logic             in_token_new;
	logic [CNT_W-1:0] tokens_new;
	logic             finish;
	logic             keep_mark;
	logic [AW-1:0]    end_new;

	assign accept   = rx.valid && rx.ready;
	assign rx.ready = !emit_q;
	assign cfg.ready = 1'b1;

	// Line limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_limit_q <= LIMIT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			line_limit_q <= cfg.line_limit;
		end
	end

	// Effective limit: zero counts as one, values above the store depth clamp.
	always_comb begin
		lim = CW'(line_limit_q);
		if (lim == '0) begin
			lim = CW'(1);
		end else if (lim > CW'(LINE_MAX)) begin
			lim = CW'(LINE_MAX);
		end
	end

	// Byte classification and the state as seen by this byte.
	always_comb begin
		eol          = rx.rx_byte inside {CH_CR, CH_LF};
		is_space     = (rx.rx_byte == CH_SPACE);
		wp_cur       = started_q ? CW'(wp_q) : '0;
		in_token_cur = started_q && in_token_q;
		tokens_cur   = started_q ? tokens_q : '0;
	end

	// Store update and line-end decision.
	always_comb begin
		we           = 1'b0;
		waddr        = AW'(wp_cur);
		wdata        = {1'b0, rx.rx_byte};
		wp_new       = wp_cur;
		in_token_new = in_token_cur;
		tokens_new   = tokens_cur;
		finish       = 1'b0;
		keep_mark    = 1'b0;
		end_new      = AW'(wp_cur);
		if (accept && (started_q || !eol)) begin
			if (eol) begin
				// The final NUL lands on a fresh entry with no token start.
				finish = 1'b1;
			end else begin
				if (wp_cur < lim) begin
					if (in_token_cur) begin
						we     = 1'b1;
						wdata  = {1'b0, is_space ? CH_NUL : rx.rx_byte};
						wp_new = wp_cur + CW'(1);
						in_token_new = !is_space;
					end else if (!is_space) begin
						we     = 1'b1;
						wdata  = {1'b1, rx.rx_byte};
						wp_new = wp_cur + CW'(1);
						in_token_new = 1'b1;
						if (tokens_cur != CNT_SAT) begin
							tokens_new = tokens_cur + CNT_W'(1);
						end
					end
				end
				// At the limit the NUL overwrites the last stored character.
				if (wp_new >= lim) begin
					finish    = 1'b1;
					keep_mark = 1'b1;
					end_new   = AW'(lim - CW'(1));
				end
			end
		end
	end

	// Line state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q  <= 1'b0;
			in_token_q <= 1'b0;
			wp_q       <= '0;
			tokens_q   <= '0;
		end else if (accept && (started_q || !eol)) begin
			started_q  <= !finish;
			in_token_q <= finish ? 1'b0 : in_token_new;
			wp_q       <= AW'(wp_new);
			tokens_q   <= tokens_new;
		end
	end

	// Read-out request, held until the reader has sent the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= 1'b0;
		end else if (finish) begin
			emit_q <= 1'b1;
		end else if (done) begin
			emit_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			keep_mark_q   <= keep_mark;
			end_q         <= end_new;
			emit_tokens_q <= tokens_new;
		end
	end

	assign end_pos       = end_q;
	assign req.valid     = emit_q;
	assign req.keep_mark = keep_mark_q;
	assign req.tokens    = emit_tokens_q;

endmodule

FILE: sv/clt_reader.sv
// ----------------------------------------------------------------------------
// Tokenizer line reader
// Walks the stored line from position zero and sends one byte per transfer.
// ----------------------------------------------------------------------------
module clt_reader #(
	parameter int LINE_MAX = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  clt_pkg::emit_req_t          req,
	input  logic [$clog2(LINE_MAX)-1:0] end_pos,
	input  logic [clt_pkg::WORD_W-1:0]  rdata,
	output logic                        re,
	output logic [$clog2(LINE_MAX)-1:0] raddr,
	output logic                        done,
	clt_tok_if.source                   tok
);
	import clt_pkg::*;

	localparam int AW = $clog2(LINE_MAX);

	rd_state_t state_q;
	rd_state_t state_d;

	logic [AW-1:0]     k_q;
	logic [AW-1:0]     end_q;
	logic              keep_mark_q;
	logic [CNT_W-1:0]  tokens_q;
	logic [POS_W-1:0]  pos_q;
	logic [BYTE_W-1:0] value_q;
	logic              mark_q;
	logic [CNT_W-1:0]  count_q;
	logic              last_q;

	logic start;
	logic load;
	logic sent;
	logic is_end;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			RD_IDLE: begin
				if (req.valid) begin
					state_d = RD_FETCH;
				end
			end
			RD_FETCH: begin
				state_d = RD_SEND;
			end
			RD_SEND: begin
				if (tok.ready) begin
					state_d = last_q ? RD_IDLE : RD_FETCH;
				end
			end
			default: begin
				state_d = RD_IDLE;
			end
		endcase
	end

	// Sequencer outputs: memory reads, result load and completion.
	always_comb begin
		start     = (state_q == RD_IDLE) && req.valid;
		load      = (state_q == RD_FETCH);
		sent      = (state_q == RD_SEND) && tok.ready;
		re        = start || (sent && !last_q);
		raddr     = start ? '0 : k_q + AW'(1);
		done      = sent && last_q;
		tok.valid = (state_q == RD_SEND);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RD_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Read position and captured line-end information.
	always_ff @(posedge clk) begin
		if (start) begin
			k_q         <= '0;
			end_q       <= end_pos;
			keep_mark_q <= req.keep_mark;
			tokens_q    <= req.tokens;
		end else if (sent && !last_q) begin
			k_q <= k_q + AW'(1);
		end
	end

	// Result register; the final position reads as NUL.
	assign is_end = (k_q == end_q);

	always_ff @(posedge clk) begin
		if (load) begin
			pos_q   <= POS_W'(k_q);
			value_q <= is_end ? CH_NUL : rdata[BYTE_W-1:0];
			mark_q  <= (is_end && !keep_mark_q) ? 1'b0 : rdata[BYTE_W];
			count_q <= is_end ? tokens_q : '0;
			last_q  <= is_end;
		end
	end

	assign tok.position    = pos_q;
	assign tok.value       = value_q;
	assign tok.token_start = mark_q;
	assign tok.token_count = count_q;
	assign tok.last        = last_q;

endmodule

FILE: sv/command_line_tokenizer.sv
// ----------------------------------------------------------------------------
// Command line tokenizer
// Splits received lines into NUL-separated tokens and sends the stored line.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                             Transfer
//  cfg      in   line_limit                                          valid & ready
//  rx       in   rx_byte                                             valid & ready
//  tok      out  position, value, token_start, token_count, last     valid & ready
//
// An accepted byte is written to the store at its transfer.
// At line end rx is held off while the line is read back: the reader first issues
// the read of position zero, then for each stored byte loads the result and sends
// it, waiting out tok stalls; the read of the next byte is issued with each send.
// Reset clears the control state; the line store needs no clearing pass.
// cfg is always ready; the block leaves it to the user to write cfg only while idle.
// ----------------------------------------------------------------------------
module command_line_tokenizer #(
	parameter int LINE_MAX = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	clt_cfg_if.sink    cfg,
	clt_byte_if.sink   rx,
	clt_tok_if.source  tok
);
	import clt_pkg::*;

	localparam int AW = $clog2(LINE_MAX);

	logic              we;
	logic [AW-1:0]     waddr;
	logic [WORD_W-1:0] wdata;
	logic              re;
	logic [AW-1:0]     raddr;
	logic [WORD_W-1:0] rdata;
	logic [AW-1:0]     end_pos;
	logic              done;
	emit_req_t         req;

	// Line building.
	clt_writer #(.LINE_MAX(LINE_MAX)) u_writer (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.cfg     (cfg),
		.done    (done),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.end_pos (end_pos),
		.req     (req)
	);

	// Line store: character with its token-start mark.
	clt_ram #(.WIDTH(WORD_W), .DEPTH(LINE_MAX)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Line read-out.
	clt_reader #(.LINE_MAX(LINE_MAX)) u_reader (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.end_pos (end_pos),
		.rdata   (rdata),
		.re      (re),
		.raddr   (raddr),
		.done    (done),
		.tok     (tok)
	);

	// Input is never taken while a line is being sent.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(rx.ready && tok.valid))
		else $error("input ready while a line is being sent");

	// The store is never written while it is being read back.
	a_no_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		re |-> !we)
		else $error("line store written during read-out");

	// The token count appears only on the final byte of a line.
	a_count_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(tok.valid && !tok.last) |-> (tok.token_count == '0))
		else $error("token count on a byte other than the last");

	// A finished line releases the input in the next cycle.
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		(tok.valid && tok.ready && tok.last) |=> rx.ready)
		else $error("input not released after the last byte");

endmodule
